// ===== rtl/core/hmt_pkg.sv =====
// shared types, constants and helpers of the hit-or-miss transform unit
package hmt_pkg;

    // default sizes handed to the top level
    localparam int HMT_KSIZE_DEF      = 3;
    localparam int HMT_MAX_WIDTH_DEF  = 1024;
    localparam int HMT_MAX_HEIGHT_DEF = 1024;
    localparam int HMT_Q_DEPTH        = 4;

    // register map
    typedef enum logic [1:0] {
        HMT_REG_WIDTH    = 2'd0,
        HMT_REG_HEIGHT   = 2'd1,
        HMT_REG_PATTERN  = 2'd2,
        HMT_REG_ROTATION = 2'd3
    } t_hmt_reg;

    localparam logic [10:0] HMT_WIDTH_RST    = 11'd1024;
    localparam logic [10:0] HMT_HEIGHT_RST   = 11'd1024;
    localparam logic [17:0] HMT_PATTERN_RST  = 18'd174762;
    localparam logic [1:0]  HMT_ROTATION_RST = 2'd0;

    // pixel and result bytes
    localparam logic [7:0] HMT_PIX_ON   = 8'hff;
    localparam logic [7:0] HMT_OUT_HIT  = 8'hff;
    localparam logic [7:0] HMT_OUT_MISS = 8'h00;

    // element entry codes
    localparam logic [1:0] HMT_ENT_OFF   = 2'd0;
    localparam logic [1:0] HMT_ENT_ON    = 2'd1;
    localparam logic [1:0] HMT_ENT_DC    = 2'd2;
    localparam logic [1:0] HMT_ENT_NEVER = 2'd3;

    // entries held by the pattern register
    localparam int HMT_PAT_ENTRIES = 9;

    // quarter-turn codes
    localparam logic [1:0] HMT_ROT_0   = 2'd0;
    localparam logic [1:0] HMT_ROT_90  = 2'd1;
    localparam logic [1:0] HMT_ROT_180 = 2'd2;
    localparam logic [1:0] HMT_ROT_270 = 2'd3;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [10:0] frame_height;
    } t_hmt_frame_cfg;

    typedef struct packed {
        logic [17:0] pattern;
        logic [1:0]  rotation;
    } t_hmt_match_cfg;

    // element entry index for neighbour offset (dx,dy) after rotation
    function automatic int f_pat_index(input logic [1:0] rot, input int dx, input int dy,
                                       input int rad, input int ksize);
        int px;
        int py;
        unique case (rot)
            HMT_ROT_0: begin
                px = dx;
                py = dy;
            end
            HMT_ROT_90: begin
                px = dy;
                py = -dx;
            end
            HMT_ROT_180: begin
                px = -dx;
                py = -dy;
            end
            HMT_ROT_270: begin
                px = -dy;
                py = dx;
            end
            default: begin
                px = dx;
                py = dy;
            end
        endcase
        return (py + rad) * ksize + (px + rad);
    endfunction

endpackage

// ===== rtl/core/hmt_queue.sv =====
// short request queue between the classifying front and the matching back
module hmt_queue #(
    parameter int DATA_W = 10,
    parameter int DEPTH  = hmt_pkg::HMT_Q_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [DATA_W-1:0]          i_push_data,
    input  logic                       i_pop,
    output logic                       o_head_valid,
    output logic [DATA_W-1:0]          o_head_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [DATA_W-1:0]   r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_head_valid = (r_count != '0);
    assign o_head_data  = r_mem[r_rd_ptr];
    assign o_count      = r_count;

endmodule

// ===== rtl/core/hmt_front.sv =====
// front end: frame counters, line store, neighbourhood window and edge masking
module hmt_front #(
    parameter int KSIZE      = hmt_pkg::HMT_KSIZE_DEF,
    parameter int MAX_WIDTH  = hmt_pkg::HMT_MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hmt_pkg::HMT_MAX_HEIGHT_DEF,
    parameter int Q_DEPTH    = hmt_pkg::HMT_Q_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hmt_pkg::t_hmt_frame_cfg      i_cfg,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_req_type,
    input  logic [7:0]                   i_pixel_value,
    input  logic [$clog2(Q_DEPTH+1)-1:0] i_q_count,
    output logic                         o_push,
    output logic [KSIZE*KSIZE:0]         o_push_data
);

    localparam int RAD       = KSIZE / 2;
    localparam int W_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int H_BITS    = $clog2(MAX_HEIGHT + 1);
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int OROW_BITS = $clog2(MAX_HEIGHT);
    localparam int IROW_BITS = $clog2(MAX_HEIGHT + KSIZE + 1);
    localparam int LEAD_BITS = $clog2(RAD * MAX_WIDTH + RAD + 1);

    // line store: per column, the bits of the previous KSIZE-1 rows, newest in bit 0
    logic [KSIZE-2:0] r_mem [MAX_WIDTH];

    // frame control
    logic                 r_idle, n_idle;
    logic                 r_emitting, n_emitting;
    logic [COL_BITS-1:0]  r_in_col, n_in_col;
    logic [IROW_BITS-1:0] r_in_row, n_in_row;
    logic [COL_BITS-1:0]  r_out_col, n_out_col;
    logic [OROW_BITS-1:0] r_out_row, n_out_row;
    logic [LEAD_BITS-1:0] r_lead, n_lead;
    logic [W_BITS-1:0]    r_cur_w;
    logic [H_BITS-1:0]    r_cur_h;
    logic [LEAD_BITS-1:0] r_delay;

    logic [W_BITS-1:0]    clamp_w, eff_w;
    logic [H_BITS-1:0]    clamp_h, eff_h;
    logic [LEAD_BITS-1:0] clamp_delay, eff_delay;

    logic accept, take, is_on, emit, last;
    logic [KSIZE-1:0] n_xmask, n_ymask;

    // stage 1
    logic                r_s1_valid;
    logic [COL_BITS-1:0] r_s1_col;
    logic                r_s1_on;
    logic                r_s1_emit;
    logic                r_s1_last;
    logic [KSIZE-1:0]    r_s1_xmask, r_s1_ymask;
    logic                r_s1_fwd;
    logic [KSIZE-2:0]    r_s1_fwd_word;
    logic [KSIZE-2:0]    r_rd_word;
    logic [KSIZE-2:0]    s1_base, s1_new_word;
    logic [KSIZE-1:0]    s1_col_vec;
    logic [KSIZE-1:0]    r_win [KSIZE];
    logic [KSIZE-1:0]    n_win [KSIZE];

    // size clamping, latched at frame start
    always_comb begin
        if (i_cfg.frame_width == '0) begin
            clamp_w = W_BITS'(1);
        end else if (32'(i_cfg.frame_width) > MAX_WIDTH) begin
            clamp_w = W_BITS'(MAX_WIDTH);
        end else begin
            clamp_w = W_BITS'(i_cfg.frame_width);
        end
        if (i_cfg.frame_height == '0) begin
            clamp_h = H_BITS'(1);
        end else if (32'(i_cfg.frame_height) > MAX_HEIGHT) begin
            clamp_h = H_BITS'(MAX_HEIGHT);
        end else begin
            clamp_h = H_BITS'(i_cfg.frame_height);
        end
    end

    assign clamp_delay = LEAD_BITS'(clamp_w) * LEAD_BITS'(RAD) + LEAD_BITS'(RAD);
    assign eff_w       = r_idle ? clamp_w : r_cur_w;
    assign eff_h       = r_idle ? clamp_h : r_cur_h;
    assign eff_delay   = r_idle ? clamp_delay : r_delay;

    assign o_in_ready = (32'(i_q_count) + 32'(r_s1_valid)) < Q_DEPTH;
    assign accept     = i_in_valid & o_in_ready;
    // padding before a frame's first pixel is dropped
    assign take       = accept & ~(r_idle & i_req_type);

    assign is_on = (r_in_row < IROW_BITS'(eff_h)) & ~i_req_type &
                   (i_pixel_value == hmt_pkg::HMT_PIX_ON);
    assign emit  = r_emitting | (r_lead == eff_delay);
    assign last  = emit & (W_BITS'(r_out_col) == eff_w - W_BITS'(1)) &
                   (H_BITS'(r_out_row) == eff_h - H_BITS'(1));

    // frame edge masks for the result position
    always_comb begin
        int x;
        int y;
        for (int j = 0; j < KSIZE; j++) begin
            x = int'(r_out_col) + j - RAD;
            n_xmask[j] = (x >= 0) && (x < int'(eff_w));
        end
        for (int k = 0; k < KSIZE; k++) begin
            y = int'(r_out_row) + k - RAD;
            n_ymask[k] = (y >= 0) && (y < int'(eff_h));
        end
    end

    always_comb begin
        n_idle     = r_idle;
        n_emitting = r_emitting;
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_lead     = r_lead;
        if (take) begin
            n_idle = 1'b0;
            if (last) begin
                n_idle     = 1'b1;
                n_emitting = 1'b0;
                n_in_col   = '0;
                n_in_row   = '0;
                n_out_col  = '0;
                n_out_row  = '0;
                n_lead     = '0;
            end else begin
                if (W_BITS'(r_in_col) == eff_w - W_BITS'(1)) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + IROW_BITS'(1);
                end else begin
                    n_in_col = r_in_col + COL_BITS'(1);
                end
                if (emit) begin
                    n_emitting = 1'b1;
                    if (W_BITS'(r_out_col) == eff_w - W_BITS'(1)) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + OROW_BITS'(1);
                    end else begin
                        n_out_col = r_out_col + COL_BITS'(1);
                    end
                end else begin
                    n_lead = r_lead + LEAD_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle     <= 1'b1;
            r_emitting <= 1'b0;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_lead     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_idle     <= n_idle;
            r_emitting <= n_emitting;
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_lead     <= n_lead;
            r_s1_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_idle) begin
            r_cur_w <= clamp_w;
            r_cur_h <= clamp_h;
            r_delay <= clamp_delay;
        end
        if (take) begin
            r_s1_col      <= r_in_col;
            r_s1_on       <= is_on;
            r_s1_emit     <= emit;
            r_s1_last     <= last;
            r_s1_xmask    <= n_xmask;
            r_s1_ymask    <= n_ymask;
            // same column written by the request ahead at this edge
            r_s1_fwd      <= r_s1_valid && (r_s1_col == r_in_col);
            r_s1_fwd_word <= s1_new_word;
            r_rd_word     <= r_mem[r_in_col];
        end
    end

    // stage 1: shift the column word, build the column vector and the window
    assign s1_base     = r_s1_fwd ? r_s1_fwd_word : r_rd_word;
    assign s1_new_word = {s1_base[KSIZE-3:0], r_s1_on};

    always_comb begin
        s1_col_vec[KSIZE-1] = r_s1_on;
        for (int k = 0; k < KSIZE - 1; k++) begin
            s1_col_vec[k] = s1_base[KSIZE-2-k];
        end
        for (int j = 0; j < KSIZE - 1; j++) begin
            n_win[j] = r_win[j+1];
        end
        n_win[KSIZE-1] = s1_col_vec;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_mem[r_s1_col] <= s1_new_word;
            r_win           <= n_win;
        end
    end

    always_comb begin
        for (int k = 0; k < KSIZE; k++) begin
            for (int j = 0; j < KSIZE; j++) begin
                o_push_data[k*KSIZE+j] = n_win[j][k] & r_s1_xmask[j] & r_s1_ymask[k];
            end
        end
        o_push_data[KSIZE*KSIZE] = r_s1_last;
    end

    assign o_push = r_s1_valid & r_s1_emit;

endmodule

// ===== rtl/core/hmt_back.sv =====
// back end: rotated element match and result register
module hmt_back #(
    parameter int KSIZE = hmt_pkg::HMT_KSIZE_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  hmt_pkg::t_hmt_match_cfg i_cfg,
    input  logic                    i_head_valid,
    input  logic [KSIZE*KSIZE:0]    i_head_data,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [7:0]              o_out_value,
    output logic                    o_last_of_frame
);

    localparam int RAD = KSIZE / 2;

    logic       r_valid;
    logic [7:0] r_value;
    logic       r_last;
    logic       hit;

    always_comb begin
        int         idx;
        logic [1:0] ent;
        logic       pix;
        hit = 1'b1;
        for (int k = 0; k < KSIZE; k++) begin
            for (int j = 0; j < KSIZE; j++) begin
                idx = hmt_pkg::f_pat_index(i_cfg.rotation, j - RAD, k - RAD, RAD, KSIZE);
                pix = i_head_data[k*KSIZE+j];
                ent = hmt_pkg::HMT_ENT_OFF;
                // entries past the register read as off
                if (idx < hmt_pkg::HMT_PAT_ENTRIES) begin
                    ent = i_cfg.pattern[2*idx +: 2];
                end
                case (ent)
                    hmt_pkg::HMT_ENT_DC: begin
                    end
                    hmt_pkg::HMT_ENT_NEVER: begin
                        hit = 1'b0;
                    end
                    hmt_pkg::HMT_ENT_ON: begin
                        if (!pix) hit = 1'b0;
                    end
                    default: begin
                        if (pix) hit = 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_pop = i_head_valid & (~r_valid | i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_value <= hit ? hmt_pkg::HMT_OUT_HIT : hmt_pkg::HMT_OUT_MISS;
            r_last  <= i_head_data[KSIZE*KSIZE];
        end
    end

    assign o_out_valid     = r_valid;
    assign o_out_value     = r_value;
    assign o_last_of_frame = r_last;

endmodule

// ===== rtl/core/hit_or_miss_transform_unit.sv =====
// top level of the binary hit-or-miss transform unit
// Binary hit-or-miss transform over a raster pixel stream, one request per clock
// sustained on both sides without output back-pressure. A pixel is on only when
// its byte is 255; everything outside the frame is off. Each result lags its
// pixel by rad rows and rad columns (rad = KSIZE/2), so every frame must be
// followed by rad*width+rad padding requests; padding before a frame's first
// pixel is dropped with no result. Width and height are clamped to 1..MAX_WIDTH
// and 1..MAX_HEIGHT and taken when a frame's first pixel arrives; pattern and
// rotation are applied as results are formed. With no back-pressure, the edge
// that takes the causing request also reads the line store; the built window is
// then pushed into the queue, and the element match is loaded into the output
// register. The line store is one memory of MAX_WIDTH words of KSIZE-1 bits,
// read and written once per taken request; it needs no clearing after reset
// since rows above the frame are masked off.
module hit_or_miss_transform_unit #(
    parameter int KSIZE      = hmt_pkg::HMT_KSIZE_DEF,
    parameter int MAX_WIDTH  = hmt_pkg::HMT_MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hmt_pkg::HMT_MAX_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel requests
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_pixel_value,
    // result requests
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_value,
    output logic        o_last_of_frame
);

    localparam int Q_DEPTH  = hmt_pkg::HMT_Q_DEPTH;
    localparam int CNT_BITS = $clog2(Q_DEPTH + 1);
    localparam int ENTRY_W  = KSIZE * KSIZE + 1;

    // configuration registers
    logic [10:0] r_frame_width;
    logic [10:0] r_frame_height;
    logic [17:0] r_pattern;
    logic [1:0]  r_rotation;
    logic        cfg_wr;

    hmt_pkg::t_hmt_frame_cfg frame_cfg;
    hmt_pkg::t_hmt_match_cfg match_cfg;

    // front to queue to back
    logic                q_push;
    logic [ENTRY_W-1:0]  q_push_data;
    logic                q_pop;
    logic                q_head_valid;
    logic [ENTRY_W-1:0]  q_head_data;
    logic [CNT_BITS-1:0] q_count;

    // no wait states on the configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= hmt_pkg::HMT_WIDTH_RST;
            r_frame_height <= hmt_pkg::HMT_HEIGHT_RST;
            r_pattern      <= hmt_pkg::HMT_PATTERN_RST;
            r_rotation     <= hmt_pkg::HMT_ROTATION_RST;
        end else if (cfg_wr) begin
            unique case (hmt_pkg::t_hmt_reg'(paddr[3:2]))
                hmt_pkg::HMT_REG_WIDTH:    r_frame_width  <= pwdata[10:0];
                hmt_pkg::HMT_REG_HEIGHT:   r_frame_height <= pwdata[10:0];
                hmt_pkg::HMT_REG_PATTERN:  r_pattern      <= pwdata[17:0];
                hmt_pkg::HMT_REG_ROTATION: r_rotation     <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    // register read-back, zero-extended to the bus
    always_comb begin
        unique case (hmt_pkg::t_hmt_reg'(paddr[3:2]))
            hmt_pkg::HMT_REG_WIDTH:    prdata = 32'(r_frame_width);
            hmt_pkg::HMT_REG_HEIGHT:   prdata = 32'(r_frame_height);
            hmt_pkg::HMT_REG_PATTERN:  prdata = 32'(r_pattern);
            hmt_pkg::HMT_REG_ROTATION: prdata = 32'(r_rotation);
            default:                   prdata = '0;
        endcase
    end

    assign frame_cfg.frame_width  = r_frame_width;
    assign frame_cfg.frame_height = r_frame_height;
    assign match_cfg.pattern      = r_pattern;
    assign match_cfg.rotation     = r_rotation;

    // front: counters, line store, window; pushes one entry per result position
    hmt_front #(
        .KSIZE      (KSIZE),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .Q_DEPTH    (Q_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (frame_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_pixel_value (i_pixel_value),
        .i_q_count     (q_count),
        .o_push        (q_push),
        .o_push_data   (q_push_data)
    );

    // decoupling queue; the front only takes a pixel when a slot is assured
    hmt_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (Q_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_data  (q_push_data),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head_data  (q_head_data),
        .o_count      (q_count)
    );

    // back: element match into the output register
    hmt_back #(
        .KSIZE (KSIZE)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (match_cfg),
        .i_head_valid    (q_head_valid),
        .i_head_data     (q_head_data),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_value     (o_out_value),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule
